### rtl/vp3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vp3_pkg
// shared widths and types for the 3d vector projection pipeline
// ----------------------------------------------------------------------------
package vp3_pkg;

    localparam int COMP_W    = 32;              // component width
    localparam int WIDE_W    = 2 * COMP_W;      // dot product and norm width
    localparam int DIV_STEPS = COMP_W;          // quotient bits produced
    localparam int LANES     = 3;

    // control that travels with an item through the divider
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } t_ctl;

    // one divider lane: partial remainder and shifting numerator / quotient
    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [COMP_W-1:0] low;
    } t_lane;

endpackage

`default_nettype wire

### rtl/vector_projection_3d_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_projection_3d_top
// projection of v onto d in signed q16.16: p = d * (v . d) / (d . d)
// ----------------------------------------------------------------------------
// pipeline: 6 front stages, 32 divider steps at one quotient bit each,
//   and 1 saturation/output stage
// throughput: one item per cycle; the whole pipe advances together and
//   stalls only when the output register holds an item not yet taken
// reset: synchronous active low, clears every stage valid bit; data
//   registers are not reset
module vector_projection_3d_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_v_x,
    input  wire logic signed [31:0] i_v_y,
    input  wire logic signed [31:0] i_v_z,
    input  wire logic signed [31:0] i_d_x,
    input  wire logic signed [31:0] i_d_y,
    input  wire logic signed [31:0] i_d_z,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_p_x,
    output logic signed [31:0]      o_p_y,
    output logic signed [31:0]      o_p_z,
    output logic                    o_zero_direction,
    output logic                    o_overflow
);
    import vp3_pkg::*;

    // global advance: the output register is free or being drained
    logic w_en;
    assign w_en    = i_ready || !o_valid;
    assign o_ready = w_en;

    // ---------------- stage 1: magnitudes and signs ----------------
    logic                r1_valid;
    logic [COMP_W-1:0]   r1_vm [LANES];
    logic [COMP_W-1:0]   r1_dm [LANES];
    logic [LANES-1:0]    r1_vn, r1_dn;
    logic [COMP_W-1:0]   w_vin [LANES];
    logic [COMP_W-1:0]   w_din [LANES];

    assign w_vin[0] = i_v_x;
    assign w_vin[1] = i_v_y;
    assign w_vin[2] = i_v_z;
    assign w_din[0] = i_d_x;
    assign w_din[1] = i_d_y;
    assign w_din[2] = i_d_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < LANES; i++) begin
                // magnitude of the most negative value still fits 32 unsigned bits
                r1_vm[i] <= w_vin[i][COMP_W-1] ? COMP_W'(0) - w_vin[i] : w_vin[i];
                r1_dm[i] <= w_din[i][COMP_W-1] ? COMP_W'(0) - w_din[i] : w_din[i];
                r1_vn[i] <= w_vin[i][COMP_W-1];
                r1_dn[i] <= w_din[i][COMP_W-1];
            end
        end
    end

    // ---------------- stage 2: 32x32 products ----------------
    logic                r2_valid;
    logic [WIDE_W-1:0]   r2_pp [LANES];     // |v_i| * |d_i|
    logic [WIDE_W-1:0]   r2_dd [LANES];     // |d_i|^2
    logic [LANES-1:0]    r2_pneg;
    logic [COMP_W-1:0]   r2_dm [LANES];
    logic [LANES-1:0]    r2_dn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < LANES; i++) begin
                r2_pp[i]   <= WIDE_W'(r1_vm[i]) * WIDE_W'(r1_dm[i]);
                r2_dd[i]   <= WIDE_W'(r1_dm[i]) * WIDE_W'(r1_dm[i]);
                r2_pneg[i] <= r1_vn[i] ^ r1_dn[i];
                r2_dm[i]   <= r1_dm[i];
            end
            r2_dn <= r1_dn;
        end
    end

    // ---------------- stage 3: sums of positive and negative terms, norm ----
    // each sum is at most 3 * 2^62, so 64 bits never wrap
    logic                r3_valid;
    logic [WIDE_W-1:0]   r3_pos, r3_negs, r3_nsq;
    logic [COMP_W-1:0]   r3_dm [LANES];
    logic [LANES-1:0]    r3_dn;
    logic [WIDE_W-1:0]   n3_pos, n3_negs;

    always_comb begin
        n3_pos  = '0;
        n3_negs = '0;
        for (int i = 0; i < LANES; i++) begin
            if (r2_pneg[i]) begin
                n3_negs = n3_negs + r2_pp[i];
            end else begin
                n3_pos = n3_pos + r2_pp[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pos  <= n3_pos;
            r3_negs <= n3_negs;
            r3_nsq  <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_dm   <= r2_dm;
            r3_dn   <= r2_dn;
        end
    end

    // ---------------- stage 4: signed dot product as sign and magnitude ----
    logic                r4_valid;
    logic [WIDE_W-1:0]   r4_smag, r4_nsq;
    logic                r4_sneg, r4_zero;
    logic [COMP_W-1:0]   r4_dm [LANES];
    logic [LANES-1:0]    r4_dn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r3_pos >= r3_negs) begin
                r4_smag <= r3_pos - r3_negs;
                r4_sneg <= 1'b0;
            end else begin
                r4_smag <= r3_negs - r3_pos;
                r4_sneg <= 1'b1;
            end
            r4_nsq  <= r3_nsq;
            r4_zero <= (r3_nsq == '0);
            r4_dm   <= r3_dm;
            r4_dn   <= r3_dn;
        end
    end

    // ---------------- stage 5: |d_i| * |S| as two 32x32 halves ----------------
    logic                r5_valid;
    logic [WIDE_W-1:0]   r5_lo [LANES];
    logic [WIDE_W-1:0]   r5_hi [LANES];
    logic [WIDE_W-1:0]   r5_nsq;
    logic                r5_zero;
    logic [LANES-1:0]    r5_neg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < LANES; i++) begin
                r5_lo[i]  <= WIDE_W'(r4_dm[i]) * WIDE_W'(r4_smag[COMP_W-1:0]);
                r5_hi[i]  <= WIDE_W'(r4_dm[i]) * WIDE_W'(r4_smag[WIDE_W-1:COMP_W]);
                r5_neg[i] <= r4_dn[i] ^ r4_sneg;
            end
            r5_nsq  <= r4_nsq;
            r5_zero <= r4_zero;
        end
    end

    // ---------------- stage 6: 96-bit numerator, loaded into divider lanes ----
    // quotient is bounded by |v| < 2^32, so the top 64 bits start below N
    t_ctl                r6_ctl;
    logic [WIDE_W-1:0]   r6_nsq;
    t_lane [LANES-1:0]   r6_lane;

    always_ff @(posedge i_clk) begin
        logic [WIDE_W+COMP_W-1:0] prod;
        if (w_en) begin
            for (int i = 0; i < LANES; i++) begin
                prod = (WIDE_W+COMP_W)'(r5_lo[i])
                     + ((WIDE_W+COMP_W)'(r5_hi[i]) << COMP_W);
                r6_lane[i].rem <= prod[WIDE_W+COMP_W-1:COMP_W];
                r6_lane[i].low <= prod[COMP_W-1:0];
            end
            r6_nsq       <= r5_nsq;
            r6_ctl.zero  <= r5_zero;
            r6_ctl.neg   <= r5_neg;
        end
    end

    // stage valid chain for the front end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_valid     <= 1'b0;
            r5_valid     <= 1'b0;
            r6_ctl.valid <= 1'b0;
        end else if (w_en) begin
            r1_valid     <= i_valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r4_valid     <= r3_valid;
            r5_valid     <= r4_valid;
            r6_ctl.valid <= r5_valid;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    t_ctl                w_ctl  [DIV_STEPS+1];
    logic [WIDE_W-1:0]   w_den  [DIV_STEPS+1];
    t_lane [LANES-1:0]   w_lane [DIV_STEPS+1];

    assign w_ctl[0]  = r6_ctl;
    assign w_den[0]  = r6_nsq;
    assign w_lane[0] = r6_lane;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        vp3_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_den   (w_den[g]),
            .i_lane  (w_lane[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_den   (w_den[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // ---------------- output stage: sign, saturation, zero direction ----
    t_ctl                w_last;
    logic [COMP_W-1:0]   n_p [LANES];
    logic [LANES-1:0]    n_ovf;
    logic                r_valid;
    logic [COMP_W-1:0]   r_p [LANES];
    logic                r_zero, r_ovf;

    assign w_last = w_ctl[DIV_STEPS];

    always_comb begin
        logic [COMP_W-1:0] q;
        for (int i = 0; i < LANES; i++) begin
            q = w_lane[DIV_STEPS][i].low;
            n_ovf[i] = 1'b0;
            if (w_last.zero) begin
                n_p[i] = '0;
            end else if (w_last.neg[i]) begin
                if (q > {1'b1, {(COMP_W-1){1'b0}}}) begin
                    n_p[i]   = {1'b1, {(COMP_W-1){1'b0}}};
                    n_ovf[i] = 1'b1;
                end else begin
                    n_p[i] = COMP_W'(0) - q;
                end
            end else begin
                if (q[COMP_W-1]) begin
                    n_p[i]   = {1'b0, {(COMP_W-1){1'b1}}};
                    n_ovf[i] = 1'b1;
                end else begin
                    n_p[i] = q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p    <= n_p;
            r_zero <= w_last.zero;
            r_ovf  <= |n_ovf;
        end
    end

    assign o_valid          = r_valid;
    assign o_p_x            = r_p[0];
    assign o_p_y            = r_p[1];
    assign o_p_z            = r_p[2];
    assign o_zero_direction = r_zero;
    assign o_overflow       = r_ovf;

    // ---------------- assertions ----------------
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_direction |->
            o_p_x == 32'sd0 && o_p_y == 32'sd0 && o_p_z == 32'sd0 && !o_overflow)
        else $error("zero direction item with nonzero result");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            o_p_x == 32'sh7fffffff || o_p_x == 32'sh80000000 ||
            o_p_y == 32'sh7fffffff || o_p_y == 32'sh80000000 ||
            o_p_z == 32'sh7fffffff || o_p_z == 32'sh80000000)
        else $error("overflow flagged with no saturated component");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r6_ctl) && $stable(r1_valid) && $stable(w_last))
        else $error("pipeline moved while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (i_ready || !o_valid))
        else $error("input ready out of step with output drain");

endmodule

`default_nettype wire

### rtl/vp3_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vp3_div_stage
// one restoring division step for all three lanes, registered
// ----------------------------------------------------------------------------
module vp3_div_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire vp3_pkg::t_ctl             i_ctl,
    input  wire logic [vp3_pkg::WIDE_W-1:0] i_den,
    input  wire vp3_pkg::t_lane [vp3_pkg::LANES-1:0] i_lane,
    output vp3_pkg::t_ctl                  o_ctl,
    output logic [vp3_pkg::WIDE_W-1:0]     o_den,
    output vp3_pkg::t_lane [vp3_pkg::LANES-1:0] o_lane
);
    import vp3_pkg::*;

    t_ctl                r_ctl;
    logic [WIDE_W-1:0]   r_den;
    t_lane [LANES-1:0]   r_lane;
    t_lane [LANES-1:0]   n_lane;

    always_comb begin
        logic [WIDE_W:0] t;
        logic [WIDE_W:0] d;
        for (int i = 0; i < LANES; i++) begin
            t = {i_lane[i].rem, i_lane[i].low[COMP_W-1]};
            d = {1'b0, i_den};
            if (t >= d) begin
                n_lane[i].rem = WIDE_W'(t - d);
                n_lane[i].low = {i_lane[i].low[COMP_W-2:0], 1'b1};
            end else begin
                n_lane[i].rem = t[WIDE_W-1:0];
                n_lane[i].low = {i_lane[i].low[COMP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.zero <= i_ctl.zero;
            r_ctl.neg  <= i_ctl.neg;
            r_den      <= i_den;
            r_lane     <= n_lane;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_den  = r_den;
    assign o_lane = r_lane;

endmodule

`default_nettype wire
